// File: hw/rtl/stu_pkg.sv
package stu_pkg;

    // coordinate mask default, pixel fields are Q12.4
    localparam int DEF_COORD_WIDTH = 16;
    localparam int PIX_W           = 16;
    localparam int FB_W            = 32;
    localparam int OUT_W           = 32;

    // numerator widths: depth is fb << 8, offsets are (fb * |p - c|) << 8
    localparam int NUM_D_W = FB_W + 8;
    localparam int NUM_O_W = FB_W + PIX_W + 8;
    localparam int DEN_O_W = 2 * PIX_W;

    // divider latency: rounding add, one stage per quotient bit, saturation
    localparam int QUO_W   = 32;
    localparam int DIV_LAT = QUO_W + 2;

    // configuration register indexes
    localparam logic [1:0] CFG_FOCAL_PIX      = 2'd0;
    localparam logic [1:0] CFG_CENTER_COL     = 2'd1;
    localparam logic [1:0] CFG_CENTER_ROW     = 2'd2;
    localparam logic [1:0] CFG_FOCAL_BASELINE = 2'd3;

    localparam logic [15:0] RST_FOCAL_PIX      = 16'd8000;
    localparam logic [15:0] RST_CENTER_COL     = 16'd5120;
    localparam logic [15:0] RST_CENTER_ROW     = 16'd3840;
    localparam logic [31:0] RST_FOCAL_BASELINE = 32'd960000;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    typedef struct packed {
        logic [15:0] focal_pix;
        logic [15:0] center_col;
        logic [15:0] center_row;
        logic [31:0] focal_baseline;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic               zero;
        logic               dneg;
        logic               xneg;
        logic               yneg;
        logic [PIX_W-1:0]   dmag;
        logic [DEN_O_W-1:0] den;
        logic [NUM_D_W-1:0] num_d;
        logic [NUM_O_W-1:0] num_x;
        logic [NUM_O_W-1:0] num_y;
    } t_item;

endpackage

// File: hw/rtl/stu_front.sv
module stu_front import stu_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_left_col,
    input  logic [15:0] i_left_row,
    input  logic [15:0] i_right_col,
    output logic        o_push,
    input  logic        i_q_ready,
    output t_item       o_item
);

    localparam int MW = (COORD_WIDTH < PIX_W) ? COORD_WIDTH : PIX_W;
    localparam logic [PIX_W-1:0] MASK = PIX_W'((17'(1) << MW) - 17'(1));

    logic             w_en;
    logic [PIX_W-1:0] w_lc, w_lr, w_rc, w_cc, w_cr;
    logic             r_v1, r_v2;
    logic             r_zero, r_dneg, r_xneg, r_yneg;
    logic [PIX_W-1:0] r_dmag, r_xmag, r_ymag, r_f;
    logic [FB_W-1:0]  r_fb;
    t_item            r_item;

    // whole front advances unless the last stage is blocked by a full queue
    assign w_en    = !r_v2 || i_q_ready;
    assign o_ready = w_en;
    assign o_push  = r_v2 && i_q_ready;
    assign o_item  = r_item;

    assign w_lc = i_left_col  & MASK;
    assign w_lr = i_left_row  & MASK;
    assign w_rc = i_right_col & MASK;
    assign w_cc = i_cfg.center_col & MASK;
    assign w_cr = i_cfg.center_row & MASK;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // stage 1: signs and magnitudes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero <= (w_lc == w_rc);
            r_dneg <= (w_lc < w_rc);
            r_dmag <= (w_lc < w_rc) ? w_rc - w_lc : w_lc - w_rc;
            r_xneg <= (w_lc < w_cc);
            r_xmag <= (w_lc < w_cc) ? w_cc - w_lc : w_lc - w_cc;
            r_yneg <= (w_lr < w_cr);
            r_ymag <= (w_lr < w_cr) ? w_cr - w_lr : w_lr - w_cr;
            r_f    <= (i_cfg.focal_pix == '0) ? PIX_W'(1) : i_cfg.focal_pix;
            r_fb   <= i_cfg.focal_baseline;
        end
    end

    // stage 2: products for the numerators and the offset denominator
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_item.zero  <= r_zero;
            r_item.dneg  <= r_dneg;
            r_item.xneg  <= r_xneg;
            r_item.yneg  <= r_yneg;
            r_item.dmag  <= r_dmag;
            r_item.den   <= DEN_O_W'(r_dmag) * DEN_O_W'(r_f);
            r_item.num_d <= {r_fb, 8'd0};
            r_item.num_x <= {(FB_W + PIX_W)'(r_fb) * (FB_W + PIX_W)'(r_xmag), 8'd0};
            r_item.num_y <= {(FB_W + PIX_W)'(r_fb) * (FB_W + PIX_W)'(r_ymag), 8'd0};
        end
    end

endmodule

// File: hw/rtl/stu_queue.sv
module stu_queue import stu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_count;
    logic           w_push, w_pop;

    assign o_ready = (r_count != (AW + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop) r_count <= r_count + 1'b1;
            else if (w_pop && !w_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_item;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW + 1)'(DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count missed a pop");

endmodule

// File: hw/rtl/stu_div.sv
module stu_div import stu_pkg::*; #(
    parameter int NUM_W = NUM_O_W,
    parameter int DEN_W = DEN_O_W
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [DEN_W-1:0]        i_den,
    input  logic                    i_neg,
    output logic signed [OUT_W-1:0] o_val,
    output logic                    o_sat
);

    localparam int RW = NUM_W + 1;
    localparam int CW = (RW > DEN_W + QUO_W + 1) ? RW : DEN_W + QUO_W + 1;

    logic [CW-1:0]    r_rem [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0] r_q   [QUO_W+1];
    logic             r_neg [QUO_W+1];
    logic             r_ovf [QUO_W+1];
    logic [RW-1:0]    w_n;
    logic             w_ovf;
    logic [QUO_W-1:0] w_q;
    logic             w_sat;

    // rounding bias and quotient overflow check
    assign w_n   = RW'(i_num) + RW'(i_den >> 1);
    assign w_ovf = CW'(w_n) >= (CW'(i_den) << QUO_W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(w_n);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= w_ovf;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QUO_W; k++) begin : g_bit
        localparam int SH = QUO_W - k;
        logic [CW-1:0] w_t;
        logic          w_ge;
        assign w_t  = CW'(r_den[k-1]) << SH;
        assign w_ge = (r_rem[k-1] >= w_t);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? r_rem[k-1] - w_t : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][QUO_W-2:0], w_ge};
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    // sign and clamp
    assign w_q   = r_q[QUO_W];
    assign w_sat = r_ovf[QUO_W] ||
                   (r_neg[QUO_W] ? (w_q > 32'h8000_0000) : (w_q > 32'h7fff_ffff));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sat <= w_sat;
            if (r_neg[QUO_W]) o_val <= w_sat ? 32'sh8000_0000 : signed'(-w_q);
            else              o_val <= w_sat ? 32'sh7fff_ffff : signed'(w_q);
        end
    end

endmodule

// File: hw/rtl/stu_back.sv
module stu_back import stu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [95:0] o_tdata,
    output logic [1:0]  o_tuser
);

    logic                    w_en;
    logic                    r_vld  [DIV_LAT];
    logic                    r_zero [DIV_LAT];
    logic signed [OUT_W-1:0] w_x, w_d, w_y;
    logic                    w_sx, w_sd, w_sy;

    // all stages move together; the last divider stage is the output word
    assign w_en     = !r_vld[DIV_LAT-1] || i_tready;
    assign o_pop    = w_en;
    assign o_tvalid = r_vld[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_q_valid;
            for (int k = 1; k < DIV_LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero[0] <= i_item.zero;
            for (int k = 1; k < DIV_LAT; k++) r_zero[k] <= r_zero[k-1];
        end
    end

    stu_div #(.NUM_W(NUM_O_W), .DEN_W(DEN_O_W)) u_div_x (
        .i_clk (i_clk), .i_en (w_en), .i_num (i_item.num_x), .i_den (i_item.den),
        .i_neg (i_item.dneg ^ i_item.xneg), .o_val (w_x), .o_sat (w_sx)
    );

    stu_div #(.NUM_W(NUM_D_W), .DEN_W(PIX_W)) u_div_d (
        .i_clk (i_clk), .i_en (w_en), .i_num (i_item.num_d), .i_den (i_item.dmag),
        .i_neg (i_item.dneg), .o_val (w_d), .o_sat (w_sd)
    );

    // robot z is the negated camera vertical offset
    stu_div #(.NUM_W(NUM_O_W), .DEN_W(DEN_O_W)) u_div_y (
        .i_clk (i_clk), .i_en (w_en), .i_num (i_item.num_y), .i_den (i_item.den),
        .i_neg (!(i_item.dneg ^ i_item.yneg)), .o_val (w_y), .o_sat (w_sy)
    );

    // zero disparity overrides the quotients
    always_comb begin
        if (r_zero[DIV_LAT-1]) begin
            o_tdata = '0;
            o_tuser = STATUS_ZERO;
        end else begin
            o_tdata = {w_y, w_d, w_x};
            o_tuser = (w_sx || w_sd || w_sy) ? STATUS_SAT : STATUS_OK;
        end
    end

endmodule

// File: hw/rtl/stereo_triangulation_unit.sv
// Stereo triangulation for a rectified pinhole pair.
// Slave stream: one matched feature per word, tdata = left column, left row,
// right column (unsigned Q12.4 pixels). Master stream: one point per word,
// tdata = lateral, depth, vertical (signed Q23.8 mm, robot axes), tuser =
// status (ok, zero disparity, saturated).
// Config channel: index 0 focal length, 1 principal column, 2 principal row,
// 3 focal-baseline product; always ready, write only while the unit is idle.
// Throughput is one word per cycle while the receiver accepts. A word passes
// the front stages, the queue and the divider pipeline, whose depth is set by
// three long dividers that settle one quotient bit per stage.
// Front and back are parted by a four-word queue, so a stalled receiver
// holds the divider pipeline while the front still fills the queue; the
// input stalls only once the queue is full.
// Reset clears the valid bits, queue pointers and count and loads the default
// camera registers (focal 500 px, centre 320/240 px, fb 60000 px-mm).
module stereo_triangulation_unit import stu_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,    // left_col, left_row, right_col
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,    // pos_lateral, pos_depth, pos_vertical
    output logic [1:0]  o_m_tuser,    // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item w_f_item, w_q_item;
    logic  w_push, w_q_ready, w_q_valid, w_pop;

    assign o_cfg_ready = 1'b1;

    // camera registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_pix      <= RST_FOCAL_PIX;
            r_cfg.center_col     <= RST_CENTER_COL;
            r_cfg.center_row     <= RST_CENTER_ROW;
            r_cfg.focal_baseline <= RST_FOCAL_BASELINE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FOCAL_PIX:      r_cfg.focal_pix      <= i_cfg_data[15:0];
                CFG_CENTER_COL:     r_cfg.center_col     <= i_cfg_data[15:0];
                CFG_CENTER_ROW:     r_cfg.center_row     <= i_cfg_data[15:0];
                CFG_FOCAL_BASELINE: r_cfg.focal_baseline <= i_cfg_data;
                default: ;
            endcase
        end
    end

    stu_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_left_col  (i_s_tdata[15:0]),
        .i_left_row  (i_s_tdata[31:16]),
        .i_right_col (i_s_tdata[47:32]),
        .o_push      (w_push),
        .i_q_ready   (w_q_ready),
        .o_item      (w_f_item)
    );

    stu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_item  (w_f_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    stu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tuser   (o_m_tuser)
    );

endmodule
